>>> hw/rtl/file_mode_expression_parser_assert.svh
`ifndef FILE_MODE_EXPRESSION_PARSER_ASSERT_SVH
`define FILE_MODE_EXPRESSION_PARSER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FMEP_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define FMEP_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> hw/rtl/fmep_pkg.sv
package fmep_pkg;

    localparam int MODE_BITS = 16;

    typedef enum logic [0:0] {
        PH_CLASS = 1'b0,
        PH_PERM  = 1'b1
    } phase_t;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_SET = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        REG_START_MODE = 2'd0,
        REG_UMASK      = 2'd1,
        REG_IS_DIR     = 2'd2
    } reg_index_t;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_W     = 8'h77;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_BIG_X = 8'h58;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;

    localparam logic [8:0]  PERM_R    = 9'o444;
    localparam logic [8:0]  PERM_W    = 9'o222;
    localparam logic [8:0]  PERM_X    = 9'o111;
    localparam logic [15:0] LOW12     = 16'o7777;
    localparam logic [2:0]  OCT_DIGITS = 3'd4;
    localparam logic [2:0]  COUNT_SAT  = 3'd5;
    localparam logic [8:0]  UMASK_RESET = 9'd18;

    typedef struct packed {
        logic [MODE_BITS-1:0] working_mode;
        logic [11:0]          octal_value;
        logic                 octal_possible;
        logic [2:0]           char_count;
        phase_t               phase;
        logic [2:0]           class_mask;
        logic                 class_explicit;
        op_t                  op;
        logic [8:0]           req_perm;
        logic [2:0]           req_special;
        logic                 failed;
    } parse_state_t;

    typedef struct packed {
        logic [MODE_BITS-1:0] mode;
        logic                 error;
    } parse_result_t;

    localparam parse_state_t STATE_CLEAR = '{
        working_mode:   '0,
        octal_value:    '0,
        octal_possible: 1'b1,
        char_count:     '0,
        phase:          PH_CLASS,
        class_mask:     '0,
        class_explicit: 1'b0,
        op:             OP_ADD,
        req_perm:       '0,
        req_special:    '0,
        failed:         1'b0
    };

    // copy one 3-bit group into every selected class
    function automatic logic [8:0] spread(input logic [2:0] three, input logic [2:0] cls);
        return {three & {3{cls[2]}}, three & {3{cls[1]}}, three & {3{cls[0]}}};
    endfunction

    function automatic logic [MODE_BITS-1:0] apply_clause(
        input logic [MODE_BITS-1:0] wm,
        input logic [2:0]           cls,
        input logic                 expl,
        input op_t                  op,
        input logic [8:0]           req_perm,
        input logic [2:0]           req_special,
        input logic [8:0]           umask
    );
        logic [8:0]           affected;
        logic [8:0]           req;
        logic [MODE_BITS-1:0] m;
        affected = spread(3'b111, cls);
        if (!expl)
        begin
            affected = affected & ~umask;
        end
        req = req_perm & affected;
        m = wm;
        if (op == OP_SET)
        begin
            m = m & ~{4'b0, cls, affected};
        end
        if (op == OP_SUB)
        begin
            m = m & ~{4'b0, req_special, req};
        end
        else
        begin
            m = m | {4'b0, req_special, req};
        end
        return m;
    endfunction

endpackage

>>> hw/rtl/fmep_step.sv
module fmep_step
    import fmep_pkg::*;
#(
    parameter int MODE_WIDTH = 16
)
(
    input  parse_state_t         cur,
    input  logic [7:0]           character,
    input  logic                 last,
    input  logic [MODE_BITS-1:0] start_mode,
    input  logic [8:0]           umask_bits,
    input  logic                 target_is_directory,
    output parse_state_t         nxt,
    output parse_result_t        res
);

    localparam int KEEP_WIDTH = (MODE_WIDTH < MODE_BITS) ? MODE_WIDTH : MODE_BITS;
    localparam logic [MODE_BITS-1:0] MODE_MASK =
        MODE_BITS'((33'd1 << KEEP_WIDTH) - 33'd1);

    parse_state_t         s;
    logic [MODE_BITS-1:0] wm;
    logic [MODE_BITS-1:0] applied;
    logic                 digit;
    logic                 is_comma;
    logic                 enter_perm;
    logic                 apply_en;

    always_comb
    begin
        wm = (cur.char_count == '0) ? (start_mode & MODE_MASK) : cur.working_mode;
        s = cur;
        s.working_mode = wm;
        is_comma = 1'b0;
        enter_perm = 1'b0;

        // octal reading
        digit = (character >= CH_0) && (character <= CH_7);
        if (digit && (cur.char_count < OCT_DIGITS))
        begin
            s.octal_value = {cur.octal_value[8:0], character[2:0]};
        end
        else
        begin
            s.octal_possible = 1'b0;
        end
        if (cur.char_count < COUNT_SAT)
        begin
            s.char_count = cur.char_count + 3'd1;
        end

        // symbolic reading
        if (!cur.failed)
        begin
            if (cur.phase == PH_CLASS)
            begin
                case (character)
                    CH_U:
                    begin
                        s.class_mask = cur.class_mask | 3'b100;
                        s.class_explicit = 1'b1;
                    end
                    CH_G:
                    begin
                        s.class_mask = cur.class_mask | 3'b010;
                        s.class_explicit = 1'b1;
                    end
                    CH_O:
                    begin
                        s.class_mask = cur.class_mask | 3'b001;
                        s.class_explicit = 1'b1;
                    end
                    CH_A:
                    begin
                        s.class_mask = 3'b111;
                        s.class_explicit = 1'b1;
                    end
                    CH_PLUS:
                    begin
                        s.op = OP_ADD;
                        enter_perm = 1'b1;
                    end
                    CH_MINUS:
                    begin
                        s.op = OP_SUB;
                        enter_perm = 1'b1;
                    end
                    CH_EQ:
                    begin
                        s.op = OP_SET;
                        enter_perm = 1'b1;
                    end
                    default:
                    begin
                        s.failed = 1'b1;
                    end
                endcase
                if (enter_perm)
                begin
                    if (!cur.class_explicit)
                    begin
                        s.class_mask = 3'b111;
                    end
                    s.phase = PH_PERM;
                    s.req_perm = '0;
                    s.req_special = '0;
                end
            end
            else
            begin
                case (character)
                    CH_COMMA: is_comma = 1'b1;
                    CH_R:     s.req_perm = cur.req_perm | PERM_R;
                    CH_W:     s.req_perm = cur.req_perm | PERM_W;
                    CH_X:     s.req_perm = cur.req_perm | PERM_X;
                    CH_BIG_X:
                    begin
                        if (target_is_directory || (|(wm[8:0] & PERM_X)))
                        begin
                            s.req_perm = cur.req_perm | PERM_X;
                        end
                    end
                    CH_S:
                    begin
                        s.req_special[2] = cur.req_special[2] | cur.class_mask[2];
                        s.req_special[1] = cur.req_special[1] | cur.class_mask[1];
                    end
                    CH_T:     s.req_special[0] = 1'b1;
                    CH_U:     s.req_perm = cur.req_perm | spread(wm[8:6], cur.class_mask);
                    CH_G:     s.req_perm = cur.req_perm | spread(wm[5:3], cur.class_mask);
                    CH_O:     s.req_perm = cur.req_perm | spread(wm[2:0], cur.class_mask);
                    default:  s.failed = 1'b1;
                endcase
            end
        end

        // clause ends on a comma or at the end of the expression
        apply_en = !s.failed && (s.phase == PH_PERM) && (is_comma || last);
        applied = apply_clause(wm, s.class_mask, s.class_explicit, s.op,
                               s.req_perm, s.req_special, umask_bits) & MODE_MASK;
        if (apply_en)
        begin
            s.working_mode = applied;
        end
        if (is_comma)
        begin
            s.phase = PH_CLASS;
            s.class_mask = '0;
            s.class_explicit = 1'b0;
        end

        if (s.octal_possible)
        begin
            res.error = 1'b0;
            res.mode = ((wm & ~LOW12) | {4'b0, s.octal_value}) & MODE_MASK;
        end
        else
        begin
            res.error = s.failed || (s.phase != PH_PERM);
            res.mode = res.error ? '0 : s.working_mode;
        end

        nxt = last ? STATE_CLEAR : s;
    end

endmodule

>>> hw/rtl/file_mode_expression_parser.sv
// channel   direction  payload (low bit first)          handshake
// s_*       in         tdata: character; tlast: last     s_tvalid / s_tready
// m_*       out        tdata: new_mode; tuser: error     m_tvalid / m_tready
// cfg_*     in         cfg_addr selects, cfg_wdata       cfg_we, no wait
//
// one character per cycle while no final character waits (see below): input register,
// then parse logic into the parse state and, on the final character, into the result register
// a final character waits in the input register only while an unread result is
// stalled by m_tready low; other characters never wait on the output side
// rst_n clears the parse state, both valid flags and the registers
// (start_mode 0, umask_bits 18, target_is_directory 0)
`include "file_mode_expression_parser_assert.svh"

module file_mode_expression_parser
    import fmep_pkg::*;
#(
    parameter int MODE_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] character
    input  logic        s_tlast,

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] new_mode
    output logic [0:0]  m_tuser,   // [0] error

    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    logic [MODE_BITS-1:0] start_mode_reg;
    logic [8:0]           umask_reg;
    logic                 is_dir_reg;

    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [7:0]           in_char_reg;
    logic                 in_last_reg;

    parse_state_t         state_reg;
    parse_state_t         state_next;
    parse_state_t         step_state;
    parse_result_t        step_res;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [MODE_BITS-1:0] out_mode_reg;
    logic                 out_error_reg;

    logic                 in_take;
    logic                 proc;
    logic                 finish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_mode_reg <= '0;
            umask_reg      <= UMASK_RESET;
            is_dir_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_addr))
                REG_START_MODE: start_mode_reg <= cfg_wdata;
                REG_UMASK:      umask_reg      <= cfg_wdata[8:0];
                REG_IS_DIR:     is_dir_reg     <= cfg_wdata[0];
                default:        ;
            endcase
        end
    end

    assign proc     = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign finish   = proc && in_last_reg;
    assign s_tready = !in_valid_reg || proc;
    assign in_take  = s_tvalid && s_tready;

    fmep_step #(
        .MODE_WIDTH (MODE_WIDTH)
    ) u_step (
        .cur                 (state_reg),
        .character           (in_char_reg),
        .last                (in_last_reg),
        .start_mode          (start_mode_reg),
        .umask_bits          (umask_reg),
        .target_is_directory (is_dir_reg),
        .nxt                 (step_state),
        .res                 (step_res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (proc)
        begin
            in_valid_next = 1'b0;
        end

        state_next = proc ? step_state : state_reg;

        out_valid_next = out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_CLEAR;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (finish)
        begin
            out_mode_reg  <= step_res.mode;
            out_error_reg <= step_res.error;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_mode_reg;
    assign m_tuser[0] = out_error_reg;

    // a result never overwrites one that has not been taken
    `FMEP_ASSERT_NOW(a_no_overwrite, finish, !out_valid_reg || m_tready, "result overwritten")
    // results come only from a final character
    `FMEP_ASSERT_NEXT(a_out_from_last, !finish && (!out_valid_reg || m_tready), !out_valid_reg, "result without final character")
    // parse state starts over after each expression
    `FMEP_ASSERT_NEXT(a_clear_after_last, finish, state_reg.char_count == '0 && !state_reg.failed && state_reg.phase == PH_CLASS, "parse state not cleared")
    // a rejected expression reports a zero mode
    `FMEP_ASSERT_NOW(a_error_zero_mode, out_valid_reg && out_error_reg, out_mode_reg == '0, "error with nonzero mode")

endmodule
